FILE: rtl/gbs_pkg.sv
// Shared types, constants and helper functions for the gene burst SSA step block.
package gbs_pkg;

	localparam logic [31:0] RNG_RESET      = 32'd123456789;
	localparam logic [31:0] LN2_Q32        = 32'd2977044472;
	localparam logic [31:0] INTERVAL_RESET = 32'd65536;
	localparam logic [31:0] SIGN_FLIP      = 32'h8000_0000;
	localparam int          NUM_RXN        = 7;
	localparam int          CFG_IDX_W      = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TO_INACTIVE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INACTIVE_TO_ACTIVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MRNA_FROM_INACTIVE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MRNA_FROM_ACTIVE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MRNA_DECAY         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PROTEIN_MAKE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PROTEIN_DECAY      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL    = 3'd7;

	// reaction codes
	localparam logic [2:0] RX_A2I     = 3'd0;
	localparam logic [2:0] RX_I2A     = 3'd1;
	localparam logic [2:0] RX_M_INACT = 3'd2;
	localparam logic [2:0] RX_M_ACT   = 3'd3;
	localparam logic [2:0] RX_M_DECAY = 3'd4;
	localparam logic [2:0] RX_P_MAKE  = 3'd5;
	localparam logic [2:0] RX_P_DECAY = 3'd6;

	// species slots
	localparam logic [1:0] SP_PROTEIN  = 2'd0;
	localparam logic [1:0] SP_ACTIVE   = 2'd1;
	localparam logic [1:0] SP_INACTIVE = 2'd2;
	localparam logic [1:0] SP_MRNA     = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_SUM, S_DRAW, S_ZERO, S_NORM, S_SQ, S_LNA, S_LNB,
		S_DIV, S_TADD, S_SAMP, S_SELA, S_SELB, S_SEL, S_EMIT, S_BUMP, S_REF
	} st_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_ACCEPT, OP_START, OP_SUM, OP_DRAW, OP_ZERO, OP_NORM, OP_SQ,
		OP_LNA, OP_LNB, OP_DIV, OP_TADD, OP_SAMP, OP_SELA, OP_SELB, OP_SEL,
		OP_EMIT, OP_BUMP, OP_REF
	} op_t;

	typedef enum logic [1:0] {
		MODE_START, MODE_FIRE, MODE_PLAIN
	} mode_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic total_zero;
		logic norm_done;
		logic iter_last;
		logic idx_last;
		logic samp_done;
		logic sel_hit;
		logic out_busy;
	} sts_t;

	// species that drives each reaction's propensity
	function automatic logic [1:0] drive_of(input logic [2:0] r);
		case (r)
			RX_A2I:     return SP_ACTIVE;
			RX_I2A:     return SP_INACTIVE;
			RX_M_INACT: return SP_INACTIVE;
			RX_M_ACT:   return SP_ACTIVE;
			RX_M_DECAY: return SP_MRNA;
			RX_P_MAKE:  return SP_MRNA;
			default:    return SP_PROTEIN;
		endcase
	endfunction

	function automatic logic [31:0] xorshift(input logic [31:0] s);
		logic [31:0] a;
		logic [31:0] b;
		a = s ^ (s << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

FILE: rtl/gbs_if.sv
// Handshake channel interfaces: input requests, results and configuration writes.
interface gbs_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] init_protein;
	logic [15:0] init_active;
	logic [15:0] init_inactive;
	logic [15:0] init_mrna;
	logic [31:0] start_time;
	logic [31:0] end_time;
	logic [15:0] sample_limit;
	logic [31:0] seed;
	modport source (output valid, kind, init_protein, init_active, init_inactive, init_mrna,
		start_time, end_time, sample_limit, seed, input ready);
	modport sink (input valid, kind, init_protein, init_active, init_inactive, init_mrna,
		start_time, end_time, sample_limit, seed, output ready);
endinterface

interface gbs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] first_sample;
	logic [15:0] sample_count;
	logic [15:0] protein_count;
	logic [15:0] active_count;
	logic [15:0] inactive_count;
	logic [15:0] mrna_count;
	logic [31:0] now_time;
	logic        finished;
	modport source (output valid, first_sample, sample_count, protein_count, active_count,
		inactive_count, mrna_count, now_time, finished, input ready);
	modport sink (input valid, first_sample, sample_count, protein_count, active_count,
		inactive_count, mrna_count, now_time, finished, output ready);
endinterface

interface gbs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gbs_pkg::CFG_IDX_W-1:0]  index;
	logic [31:0]                    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/gbs_ctrl.sv
// Sequencer for the step: start load, propensity sum, draw, log, divide, samples, select, refresh.
module gbs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_kind,
	input  gbs_pkg::sts_t  sts,
	output logic           in_ready,
	output gbs_pkg::cmd_t  cmd
);

	gbs_pkg::st_t   state_q, state_d;
	gbs_pkg::mode_t mode_q, mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbs_pkg::S_IDLE;
			mode_q  <= gbs_pkg::MODE_PLAIN;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		in_ready = 1'b0;
		cmd.op   = gbs_pkg::OP_NONE;
		case (state_q)
			gbs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = gbs_pkg::OP_ACCEPT;
					if (!in_kind) begin
						state_d = gbs_pkg::S_START;
						mode_d  = gbs_pkg::MODE_START;
					end else if (sts.done) begin
						state_d = gbs_pkg::S_EMIT;
						mode_d  = gbs_pkg::MODE_PLAIN;
					end else begin
						state_d = gbs_pkg::S_SUM;
						mode_d  = gbs_pkg::MODE_FIRE;
					end
				end
			end
			gbs_pkg::S_START: begin
				cmd.op  = gbs_pkg::OP_START;
				state_d = gbs_pkg::S_REF;
			end
			gbs_pkg::S_SUM: begin
				cmd.op = gbs_pkg::OP_SUM;
				if (sts.idx_last) state_d = gbs_pkg::S_DRAW;
			end
			gbs_pkg::S_DRAW: begin
				cmd.op  = gbs_pkg::OP_DRAW;
				state_d = sts.total_zero ? gbs_pkg::S_ZERO : gbs_pkg::S_NORM;
			end
			gbs_pkg::S_ZERO: begin
				cmd.op  = gbs_pkg::OP_ZERO;
				mode_d  = gbs_pkg::MODE_PLAIN;
				state_d = gbs_pkg::S_EMIT;
			end
			gbs_pkg::S_NORM: begin
				if (sts.norm_done) state_d = gbs_pkg::S_SQ;
				else cmd.op = gbs_pkg::OP_NORM;
			end
			gbs_pkg::S_SQ: begin
				cmd.op = gbs_pkg::OP_SQ;
				if (sts.iter_last) state_d = gbs_pkg::S_LNA;
			end
			gbs_pkg::S_LNA: begin
				cmd.op  = gbs_pkg::OP_LNA;
				state_d = gbs_pkg::S_LNB;
			end
			gbs_pkg::S_LNB: begin
				cmd.op  = gbs_pkg::OP_LNB;
				state_d = gbs_pkg::S_DIV;
			end
			gbs_pkg::S_DIV: begin
				cmd.op = gbs_pkg::OP_DIV;
				if (sts.iter_last) state_d = gbs_pkg::S_TADD;
			end
			gbs_pkg::S_TADD: begin
				cmd.op  = gbs_pkg::OP_TADD;
				state_d = gbs_pkg::S_SAMP;
			end
			gbs_pkg::S_SAMP: begin
				if (sts.samp_done) state_d = gbs_pkg::S_SELA;
				else cmd.op = gbs_pkg::OP_SAMP;
			end
			gbs_pkg::S_SELA: begin
				cmd.op  = gbs_pkg::OP_SELA;
				state_d = gbs_pkg::S_SELB;
			end
			gbs_pkg::S_SELB: begin
				cmd.op  = gbs_pkg::OP_SELB;
				state_d = gbs_pkg::S_SEL;
			end
			gbs_pkg::S_SEL: begin
				cmd.op = gbs_pkg::OP_SEL;
				if (sts.sel_hit) state_d = gbs_pkg::S_EMIT;
			end
			gbs_pkg::S_EMIT: begin
				// hold until the result register is free
				if (!sts.out_busy) begin
					cmd.op  = gbs_pkg::OP_EMIT;
					state_d = (mode_q == gbs_pkg::MODE_FIRE) ? gbs_pkg::S_BUMP : gbs_pkg::S_IDLE;
				end
			end
			gbs_pkg::S_BUMP: begin
				cmd.op  = gbs_pkg::OP_BUMP;
				state_d = gbs_pkg::S_REF;
			end
			gbs_pkg::S_REF: begin
				cmd.op = gbs_pkg::OP_REF;
				if (sts.idx_last)
					state_d = (mode_q == gbs_pkg::MODE_START) ? gbs_pkg::S_EMIT : gbs_pkg::S_IDLE;
			end
			default: state_d = gbs_pkg::S_IDLE;
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == gbs_pkg::OP_EMIT |-> !sts.out_busy)
		else $error("result written while result register busy");

	a_step_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbs_pkg::S_IDLE && in_valid && in_kind && !sts.done)
		|=> state_q == gbs_pkg::S_SUM)
		else $error("live step request did not start the propensity sum");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gbs_pkg::S_IDLE) |-> !in_ready)
		else $error("request taken while a step is in flight");

endmodule

FILE: rtl/gbs_dp.sv
// Datapath: state registers, generator, log and divide units, selection and refresh.
module gbs_dp #(
	parameter int COUNT_BITS     = 16,
	parameter int TIME_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gbs_pkg::cmd_t                 cmd,
	output gbs_pkg::sts_t                 sts,
	input  logic [15:0]                   init_protein,
	input  logic [15:0]                   init_active,
	input  logic [15:0]                   init_inactive,
	input  logic [15:0]                   init_mrna,
	input  logic [31:0]                   start_time,
	input  logic [31:0]                   end_time,
	input  logic [15:0]                   sample_limit,
	input  logic [31:0]                   seed,
	input  logic                          cfg_valid,
	input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [15:0]                   first_sample,
	output logic [15:0]                   sample_count,
	output logic [15:0]                   protein_count,
	output logic [15:0]                   active_count,
	output logic [15:0]                   inactive_count,
	output logic [15:0]                   mrna_count,
	output logic [31:0]                   now_time,
	output logic                          finished
);

	localparam int PROP_W = 24 + COUNT_BITS;
	localparam int TOT_W  = PROP_W + 3;
	localparam int L_W    = 38;
	localparam int NUM_W  = L_W + TIME_FRAC_BITS - 16;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [2:0] LAST_RXN = 3'(gbs_pkg::NUM_RXN - 1);

	logic [23:0]           rate_q [gbs_pkg::NUM_RXN];
	logic [31:0]           interval_q;
	logic [COUNT_BITS-1:0] count_q [4];
	logic [PROP_W-1:0]     prop_q [gbs_pkg::NUM_RXN];
	logic [31:0]           rng_q, time_q, stop_q;
	logic [15:0]           next_q, limit_q, first_q;
	logic                  done_q;

	logic [15:0]           ip_q, ia_q, ii_q, im_q, lim_in_q;
	logic [31:0]           st_in_q, end_in_q, seed_q;

	logic [2:0]            idx_q, hi_q, r_q;
	logic [TOT_W-1:0]      acc_q, total_q, rem_q, pa_q;
	logic [TOT_W:0]        p_q;
	logic [31:0]           x_q, u2_q, f_q;
	logic [4:0]            k_q;
	logic [5:0]            iter_q, hi6_q;
	logic [63:0]           lnp_q;
	logic [NUM_W-1:0]      num_q, quo_q;
	logic [47:0]           samp_q;
	logic                  out_valid_q;

	logic [PROP_W-1:0]     prop_rd, prop_new;
	logic [TOT_W-1:0]      acc_n;
	logic                  hit;
	logic [31:0]           rng1, rng2, u1, u2;
	logic [63:0]           sq64;
	logic [32:0]           sq33;
	logic [37:0]           n38, lhi, lval;
	logic [L_W+TIME_FRAC_BITS-1:0] numx;
	logic [TOT_W:0]        rem_n, rem_sub;
	logic                  ge;
	logic [63:0]           t_full;
	logic [31:0]           t_sat;
	logic [47:0]           samp_mul;
	logic                  samp_go;
	logic [TOT_W-1:0]      pa;
	logic [63:0]           pb;

	function automatic logic [COUNT_BITS-1:0] clampc(input logic [15:0] v);
		if (33'(v) > 33'(CMAX)) return CMAX;
		return COUNT_BITS'(v);
	endfunction

	function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] v);
		return (v == CMAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [COUNT_BITS-1:0] dec_sat(input logic [COUNT_BITS-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

	assign prop_rd  = prop_q[idx_q];
	assign acc_n    = acc_q + TOT_W'(prop_rd);
	assign hit      = (p_q < (TOT_W+1)'(acc_n)) || (idx_q == LAST_RXN);
	assign prop_new = PROP_W'(rate_q[idx_q]) * PROP_W'(count_q[gbs_pkg::drive_of(idx_q)]);

	assign rng1 = gbs_pkg::xorshift(rng_q);
	assign rng2 = gbs_pkg::xorshift(rng1);
	assign u1   = (rng_q + rng1) ^ gbs_pkg::SIGN_FLIP;
	assign u2   = (rng1 + rng2) ^ gbs_pkg::SIGN_FLIP;

	// one bit of log2 per square
	assign sq64 = 64'(x_q) * 64'(x_q);
	assign sq33 = sq64[63:31];

	assign n38  = {6'(k_q) + 6'd1, 32'd0} - 38'(f_q);
	assign lhi  = 38'(hi6_q) * 38'(gbs_pkg::LN2_Q32);
	assign lval = lhi + 38'(lnp_q[63:32]);
	assign numx = {lval, TIME_FRAC_BITS'(0)};

	assign rem_n   = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_n >= {1'b0, total_q};
	assign rem_sub = rem_n - {1'b0, total_q};

	assign t_full = 64'(time_q) + 64'(quo_q);
	assign t_sat  = (|t_full[63:32]) ? '1 : t_full[31:0];

	assign samp_mul = 48'(next_q) * 48'(interval_q);
	assign samp_go  = (next_q < limit_q) && (48'(time_q) > samp_q);

	assign pa = TOT_W'(TOT_W'(u2_q) * TOT_W'(total_q[TOT_W-1:32]));
	assign pb = 64'(u2_q) * 64'(total_q[31:0]);

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gbs_pkg::NUM_RXN; i++) begin
				rate_q[i] <= '0;
				prop_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) count_q[i] <= '0;
			interval_q  <= gbs_pkg::INTERVAL_RESET;
			rng_q       <= gbs_pkg::RNG_RESET;
			time_q      <= '0;
			stop_q      <= '0;
			next_q      <= '0;
			limit_q     <= '0;
			done_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == gbs_pkg::REG_SAMPLE_INTERVAL) interval_q <= cfg_data;
				else rate_q[cfg_index] <= cfg_data[23:0];
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				gbs_pkg::OP_START: begin
					count_q[gbs_pkg::SP_PROTEIN]  <= clampc(ip_q);
					count_q[gbs_pkg::SP_ACTIVE]   <= clampc(ia_q);
					count_q[gbs_pkg::SP_INACTIVE] <= clampc(ii_q);
					count_q[gbs_pkg::SP_MRNA]     <= clampc(im_q);
					time_q  <= st_in_q;
					stop_q  <= end_in_q;
					limit_q <= lim_in_q;
					rng_q   <= rng_q ^ seed_q;
					next_q  <= '0;
					done_q  <= st_in_q >= end_in_q;
				end
				gbs_pkg::OP_DRAW: rng_q <= rng2;
				gbs_pkg::OP_ZERO: begin
					time_q <= '1;
					if (next_q < limit_q) next_q <= limit_q;
					done_q <= 1'b1;
				end
				gbs_pkg::OP_TADD: begin
					time_q <= t_sat;
					if (t_sat >= stop_q) done_q <= 1'b1;
				end
				gbs_pkg::OP_SAMP: next_q <= next_q + 16'd1;
				gbs_pkg::OP_EMIT: out_valid_q <= 1'b1;
				gbs_pkg::OP_BUMP: begin
					case (r_q)
						gbs_pkg::RX_A2I: begin
							count_q[gbs_pkg::SP_ACTIVE]   <= dec_sat(count_q[gbs_pkg::SP_ACTIVE]);
							count_q[gbs_pkg::SP_INACTIVE] <= inc_sat(count_q[gbs_pkg::SP_INACTIVE]);
						end
						gbs_pkg::RX_I2A: begin
							count_q[gbs_pkg::SP_ACTIVE]   <= inc_sat(count_q[gbs_pkg::SP_ACTIVE]);
							count_q[gbs_pkg::SP_INACTIVE] <= dec_sat(count_q[gbs_pkg::SP_INACTIVE]);
						end
						gbs_pkg::RX_M_INACT, gbs_pkg::RX_M_ACT:
							count_q[gbs_pkg::SP_MRNA] <= inc_sat(count_q[gbs_pkg::SP_MRNA]);
						gbs_pkg::RX_M_DECAY:
							count_q[gbs_pkg::SP_MRNA] <= dec_sat(count_q[gbs_pkg::SP_MRNA]);
						gbs_pkg::RX_P_MAKE:
							count_q[gbs_pkg::SP_PROTEIN] <= inc_sat(count_q[gbs_pkg::SP_PROTEIN]);
						default:
							count_q[gbs_pkg::SP_PROTEIN] <= dec_sat(count_q[gbs_pkg::SP_PROTEIN]);
					endcase
				end
				gbs_pkg::OP_REF: prop_q[idx_q] <= prop_new;
				default: ;
			endcase
		end
	end

	// working registers of the step
	always_ff @(posedge clk) begin
		case (cmd.op)
			gbs_pkg::OP_ACCEPT: begin
				ip_q     <= init_protein;
				ia_q     <= init_active;
				ii_q     <= init_inactive;
				im_q     <= init_mrna;
				st_in_q  <= start_time;
				end_in_q <= end_time;
				lim_in_q <= sample_limit;
				seed_q   <= seed;
				first_q  <= next_q;
				idx_q    <= '0;
				hi_q     <= LAST_RXN;
				acc_q    <= '0;
			end
			gbs_pkg::OP_START: begin
				first_q <= '0;
				idx_q   <= '0;
				hi_q    <= LAST_RXN;
			end
			gbs_pkg::OP_SUM: begin
				acc_q <= acc_n;
				idx_q <= idx_q + 3'd1;
			end
			gbs_pkg::OP_DRAW: begin
				total_q <= acc_q;
				x_q     <= (u1 == '0) ? 32'd1 : u1;
				u2_q    <= u2;
				k_q     <= '0;
				f_q     <= '0;
				iter_q  <= 6'd31;
			end
			gbs_pkg::OP_NORM: begin
				x_q <= x_q << 1;
				k_q <= k_q + 5'd1;
			end
			gbs_pkg::OP_SQ: begin
				x_q    <= sq33[32] ? sq33[32:1] : sq33[31:0];
				f_q    <= {f_q[30:0], sq33[32]};
				iter_q <= iter_q - 6'd1;
			end
			gbs_pkg::OP_LNA: begin
				hi6_q <= n38[37:32];
				lnp_q <= 64'(n38[31:0]) * 64'(gbs_pkg::LN2_Q32);
			end
			gbs_pkg::OP_LNB: begin
				num_q  <= numx[L_W+TIME_FRAC_BITS-1:16];
				rem_q  <= '0;
				quo_q  <= '0;
				iter_q <= 6'(NUM_W - 1);
			end
			gbs_pkg::OP_DIV: begin
				rem_q  <= ge ? rem_sub[TOT_W-1:0] : rem_n[TOT_W-1:0];
				quo_q  <= {quo_q[NUM_W-2:0], ge};
				num_q  <= num_q << 1;
				iter_q <= iter_q - 6'd1;
			end
			gbs_pkg::OP_TADD: samp_q <= samp_mul;
			gbs_pkg::OP_SAMP: samp_q <= samp_q + 48'(interval_q);
			gbs_pkg::OP_SELA: pa_q <= pa;
			gbs_pkg::OP_SELB: begin
				p_q   <= (TOT_W+1)'(pa_q) + (TOT_W+1)'(pb[63:32]);
				acc_q <= '0;
				idx_q <= '0;
			end
			gbs_pkg::OP_SEL: begin
				acc_q <= acc_n;
				idx_q <= idx_q + 3'd1;
				if (hit) r_q <= idx_q;
			end
			gbs_pkg::OP_EMIT: begin
				first_sample   <= first_q;
				sample_count   <= next_q - first_q;
				protein_count  <= 16'(count_q[gbs_pkg::SP_PROTEIN]);
				active_count   <= 16'(count_q[gbs_pkg::SP_ACTIVE]);
				inactive_count <= 16'(count_q[gbs_pkg::SP_INACTIVE]);
				mrna_count     <= 16'(count_q[gbs_pkg::SP_MRNA]);
				now_time       <= time_q;
				finished       <= done_q;
			end
			gbs_pkg::OP_BUMP: begin
				// promoter moves touch every propensity driven by the two promoter counts
				case (r_q)
					gbs_pkg::RX_A2I, gbs_pkg::RX_I2A: begin
						idx_q <= gbs_pkg::RX_A2I;
						hi_q  <= gbs_pkg::RX_M_ACT;
					end
					gbs_pkg::RX_M_INACT, gbs_pkg::RX_M_ACT, gbs_pkg::RX_M_DECAY: begin
						idx_q <= gbs_pkg::RX_M_DECAY;
						hi_q  <= gbs_pkg::RX_P_MAKE;
					end
					default: begin
						idx_q <= gbs_pkg::RX_P_DECAY;
						hi_q  <= gbs_pkg::RX_P_DECAY;
					end
				endcase
			end
			gbs_pkg::OP_REF: idx_q <= idx_q + 3'd1;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	assign sts.done       = done_q;
	assign sts.total_zero = (acc_q == '0);
	assign sts.norm_done  = x_q[31];
	assign sts.iter_last  = (iter_q == '0);
	assign sts.idx_last   = (idx_q == hi_q);
	assign sts.samp_done  = !samp_go;
	assign sts.sel_hit    = hit;
	assign sts.out_busy   = out_valid_q && !out_ready;

endmodule

FILE: rtl/gene_burst_ssa_step.sv
// Top level of the gene burst SSA step block: controller, datapath and channel wiring.
//
//  channel  dir  carries
//  in_ch    in   start or step request (kind, initial counts, times, limit, seed)
//  out_ch   out  one result per request (samples crossed, counts, time, finished)
//  cfg_ch   in   register index and write data, always ready
//
// A start request runs accept, load, seven propensity products and the result write. A live
// step runs accept, propensity sum, draw, normalisation of u1, squarings for 32 fraction bits
// of log2, the ln2 scale, a divide giving 38 + TIME_FRAC_BITS - 16 quotient bits one per step,
// time and samples with a step per sample crossed, select, result write, fire and refresh.
// A zero-total step: accept, sum, draw, zero, write; a step after the end: accept and write.
// Reset restores every count, time and rate at once; a held result stalls the next write.
module gene_burst_ssa_step #(
	parameter int COUNT_BITS     = 16,
	parameter int TIME_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	gbs_in_if.sink    in_ch,
	gbs_out_if.source out_ch,
	gbs_cfg_if.sink   cfg_ch
);

	gbs_pkg::cmd_t cmd;
	gbs_pkg::sts_t sts;

	assign cfg_ch.ready = 1'b1;

	gbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.sts      (sts),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	gbs_dp #(
		.COUNT_BITS     (COUNT_BITS),
		.TIME_FRAC_BITS (TIME_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.init_protein   (in_ch.init_protein),
		.init_active    (in_ch.init_active),
		.init_inactive  (in_ch.init_inactive),
		.init_mrna      (in_ch.init_mrna),
		.start_time     (in_ch.start_time),
		.end_time       (in_ch.end_time),
		.sample_limit   (in_ch.sample_limit),
		.seed           (in_ch.seed),
		.cfg_valid      (cfg_ch.valid),
		.cfg_index      (cfg_ch.index),
		.cfg_data       (cfg_ch.data),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.first_sample   (out_ch.first_sample),
		.sample_count   (out_ch.sample_count),
		.protein_count  (out_ch.protein_count),
		.active_count   (out_ch.active_count),
		.inactive_count (out_ch.inactive_count),
		.mrna_count     (out_ch.mrna_count),
		.now_time       (out_ch.now_time),
		.finished       (out_ch.finished)
	);

endmodule
